// ===== src/qbsp_pkg.sv =====
package qbsp_pkg;

   // Blend weights share a factor of five, so the sum is worked at scale 200.
   localparam int SCALE       = 1000;
   localparam int WEIGHT_UNIT = 5;
   localparam int RED_SCALE   = SCALE / WEIGHT_UNIT;
   localparam int RED_BIAS    = RED_SCALE / 2;
   localparam int STEPS       = 10;
   localparam int STEP_WIDTH  = $clog2(STEPS);
   // 200 = 8 * 25: drop three bits, then divide by 25.
   localparam int DROP_SHIFT  = 3;
   localparam int ODD_DIV     = RED_SCALE >> DROP_SHIFT;

   localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(STEPS - 1);

   localparam logic KIND_START   = 1'b0;
   localparam logic KIND_CONTROL = 1'b1;

   typedef logic [7:0] weight_type;

   typedef struct packed {
      logic valid;
      logic load;
      logic last;
   } ctl_type;

   // Weight on the incoming control point: j^2.
   function automatic weight_type weight_new(input logic [STEP_WIDTH-1:0] j);
      int jj;
      jj = int'(j);
      return weight_type'(jj * jj);
   endfunction

   // Weight on the newer stored point: (3*SCALE/4 - 10(j-5)^2) / 5.
   function automatic weight_type weight_mid(input logic [STEP_WIDTH-1:0] j);
      int d;
      d = int'(j) - 5;
      return weight_type'((3 * SCALE / 4) / WEIGHT_UNIT - (10 / WEIGHT_UNIT) * d * d);
   endfunction

   // Weight on the older stored point: (j-10)^2.
   function automatic weight_type weight_old(input logic [STEP_WIDTH-1:0] j);
      int d;
      d = int'(j) - STEPS;
      return weight_type'(d * d);
   endfunction

endpackage

// ===== src/qbsp_seq.sv =====
module qbsp_seq #(
   parameter int W = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_kind,
   input  logic signed [W-1:0]             req_x_coord,
   input  logic signed [W-1:0]             req_y_coord,
   input  logic                            req_final_point,
   input  logic                            advance,
   output qbsp_pkg::ctl_type               tok_ctl,
   output logic [qbsp_pkg::STEP_WIDTH-1:0] tok_j,
   output logic signed [W-1:0]             tok_o_x,
   output logic signed [W-1:0]             tok_o_y,
   output logic signed [W-1:0]             tok_m_x,
   output logic signed [W-1:0]             tok_m_y,
   output logic signed [W-1:0]             tok_n_x,
   output logic signed [W-1:0]             tok_n_y
);
   import qbsp_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  load_ff, load_in;
   logic                  final_ff, final_in;
   logic [STEP_WIDTH-1:0] j_ff, j_in;
   logic signed [W-1:0]   older_x_ff, older_x_in, older_y_ff, older_y_in;
   logic signed [W-1:0]   newer_x_ff, newer_x_in, newer_y_ff, newer_y_in;
   logic signed [W-1:0]   o_x_ff, o_x_in, o_y_ff, o_y_in;
   logic signed [W-1:0]   m_x_ff, m_x_in, m_y_ff, m_y_in;
   logic signed [W-1:0]   n_x_ff, n_x_in, n_y_ff, n_y_in;
   logic                  job_done;
   logic                  take;

   always_comb begin
      job_done  = load_ff || (j_ff == LAST_STEP && !final_ff);
      req_ready = !busy_ff || (advance && job_done);
      take      = req_valid && req_ready;

      busy_in    = busy_ff;
      load_in    = load_ff;
      final_in   = final_ff;
      j_in       = j_ff;
      older_x_in = older_x_ff;
      older_y_in = older_y_ff;
      newer_x_in = newer_x_ff;
      newer_y_in = newer_y_ff;
      o_x_in     = o_x_ff;
      o_y_in     = o_y_ff;
      m_x_in     = m_x_ff;
      m_y_in     = m_y_ff;
      n_x_in     = n_x_ff;
      n_y_in     = n_y_ff;

      if (busy_ff && advance) begin
         if (job_done) begin
            busy_in = 1'b0;
         end else if (j_ff == LAST_STEP) begin
            // final span: double the last point
            j_in     = '0;
            final_in = 1'b0;
            o_x_in   = m_x_ff;
            o_y_in   = m_y_ff;
            m_x_in   = n_x_ff;
            m_y_in   = n_y_ff;
         end else begin
            j_in = j_ff + 1'b1;
         end
      end

      if (take) begin
         busy_in  = 1'b1;
         j_in     = '0;
         n_x_in   = req_x_coord;
         n_y_in   = req_y_coord;
         if (req_kind == KIND_START) begin
            load_in    = 1'b1;
            final_in   = 1'b0;
            older_x_in = req_x_coord;
            older_y_in = req_y_coord;
            newer_x_in = req_x_coord;
            newer_y_in = req_y_coord;
         end else begin
            load_in    = 1'b0;
            final_in   = req_final_point;
            o_x_in     = older_x_ff;
            o_y_in     = older_y_ff;
            m_x_in     = newer_x_ff;
            m_y_in     = newer_y_ff;
            older_x_in = newer_x_ff;
            older_y_in = newer_y_ff;
            newer_x_in = req_x_coord;
            newer_y_in = req_y_coord;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b0;
         load_ff    <= 1'b0;
         final_ff   <= 1'b0;
         j_ff       <= '0;
         older_x_ff <= '0;
         older_y_ff <= '0;
         newer_x_ff <= '0;
         newer_y_ff <= '0;
      end else begin
         busy_ff    <= busy_in;
         load_ff    <= load_in;
         final_ff   <= final_in;
         j_ff       <= j_in;
         older_x_ff <= older_x_in;
         older_y_ff <= older_y_in;
         newer_x_ff <= newer_x_in;
         newer_y_ff <= newer_y_in;
      end
   end

   always_ff @(posedge clock) begin
      o_x_ff <= o_x_in;
      o_y_ff <= o_y_in;
      m_x_ff <= m_x_in;
      m_y_ff <= m_y_in;
      n_x_ff <= n_x_in;
      n_y_ff <= n_y_in;
   end

   always_comb begin
      tok_ctl.valid = busy_ff;
      tok_ctl.load  = load_ff;
      tok_ctl.last  = busy_ff && !load_ff && j_ff == LAST_STEP && !final_ff;
      tok_j         = j_ff;
      tok_o_x       = o_x_ff;
      tok_o_y       = o_y_ff;
      tok_m_x       = m_x_ff;
      tok_m_y       = m_y_ff;
      tok_n_x       = n_x_ff;
      tok_n_y       = n_y_ff;
   end

endmodule

// ===== src/qbsp_blend.sv =====
module qbsp_blend #(
   parameter int W = 16
) (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [qbsp_pkg::STEP_WIDTH-1:0] j,
   input  logic signed [W-1:0]             o,
   input  logic signed [W-1:0]             m,
   input  logic signed [W-1:0]             n,
   output logic signed [W-1:0]             quot,
   output logic signed [W-1:0]             pt
);
   import qbsp_pkg::*;

   // Products and sums: |sum| < 200 * 2^(W-1) + 100 < 2^(W+7).
   localparam int PW    = W + 9;
   // Magnitude after dropping three bits.
   localparam int VW    = W + 4;
   localparam int MW    = 2 * VW - 4;
   localparam logic [VW-1:0] RECIP = VW'((64'd1 << VW) / 64'(ODD_DIV));

   logic signed [PW-1:0] pn_ff, pn_in, pm_ff, pm_in, po_ff, po_in;
   logic signed [W-1:0]  pt_a_ff, pt_b_ff, pt_c_ff;
   logic signed [PW-1:0] u;
   logic [PW-1:0]        mag;
   logic [VW-1:0]        v_ff, v_in, v_c_ff;
   logic                 neg_ff, neg_in, neg_c_ff;
   logic [MW-1:0]        prod;
   logic [W-1:0]         q0_ff, q0_in;
   logic [VW-1:0]        rem;
   logic                 bump;
   logic [W:0]           qmag;
   logic [W:0]           qsig;

   // Stage A: three weighted terms.
   always_comb begin
      pn_in = PW'(n) * PW'($signed({1'b0, weight_new(j)}));
      pm_in = PW'(m) * PW'($signed({1'b0, weight_mid(j)}));
      po_in = PW'(o) * PW'($signed({1'b0, weight_old(j)}));
   end

   // Stage B: sum with bias, split into sign and magnitude / 8.
   always_comb begin
      u      = pn_ff + pm_ff + po_ff + PW'(RED_BIAS);
      neg_in = u[PW-1];
      mag    = neg_in ? PW'(-u) : PW'(u);
      v_in   = mag[DROP_SHIFT+VW-1:DROP_SHIFT];
   end

   // Stage C: reciprocal estimate of v / 25, low by at most one.
   always_comb begin
      prod  = MW'(v_ff) * MW'(RECIP);
      q0_in = prod[MW-1:VW];
   end

   // Correct the estimate and restore the sign.
   always_comb begin
      rem  = v_c_ff - VW'(q0_ff) * VW'(ODD_DIV);
      bump = rem >= VW'(ODD_DIV);
      qmag = {1'b0, q0_ff} + (W+1)'(bump);
      qsig = neg_c_ff ? (W+1)'(-qmag) : qmag;
      quot = qsig[W-1:0];
      pt   = pt_c_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pn_ff    <= pn_in;
         pm_ff    <= pm_in;
         po_ff    <= po_in;
         pt_a_ff  <= n;
         v_ff     <= v_in;
         neg_ff   <= neg_in;
         pt_b_ff  <= pt_a_ff;
         q0_ff    <= q0_in;
         v_c_ff   <= v_ff;
         neg_c_ff <= neg_ff;
         pt_c_ff  <= pt_b_ff;
      end
   end

endmodule

// ===== src/quadratic_bspline_point_generator_top.sv =====
// Channel   Ports                                       Direction   Moves
// req       req_valid/req_ready, kind, x, y, final      in          one point item
// rsp       rsp_valid/rsp_ready, from/to x,y, end_of_run out         one segment item
//
// A control point item gives ten segments (twenty when it carries final_point),
// one segment per cycle while rsp does not stall, set by the step counter of the
// span sequencer. A start point item gives no segment. An accepted item passes the
// sequencer registers, blend stages A, B and C and then the output register.
// Reset is synchronous and clears the stored points, the pen and all valid bits.
// A stall on rsp freezes the whole pipeline; req is taken again in the cycle
// the last step of the current item moves on.
module quadratic_bspline_point_generator_top #(
   parameter int COORD_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_kind,
   input  logic signed [COORD_WIDTH-1:0] req_x_coord,
   input  logic signed [COORD_WIDTH-1:0] req_y_coord,
   input  logic                          req_final_point,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_from_x,
   output logic signed [COORD_WIDTH-1:0] rsp_from_y,
   output logic signed [COORD_WIDTH-1:0] rsp_to_x,
   output logic signed [COORD_WIDTH-1:0] rsp_to_y,
   output logic                          rsp_end_of_run
);
   import qbsp_pkg::*;

   localparam int W = COORD_WIDTH;

   logic                  advance;
   ctl_type               tok_ctl;
   logic [STEP_WIDTH-1:0] tok_j;
   logic signed [W-1:0]   tok_o_x, tok_o_y, tok_m_x, tok_m_y, tok_n_x, tok_n_y;
   logic signed [W-1:0]   quot_x, quot_y, pt_x, pt_y;

   // Control for the three datapath stages, in step with the blend units.
   ctl_type               s1_ctl_ff, s2_ctl_ff, s3_ctl_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]   from_x_ff, from_y_ff, to_x_ff, to_y_ff;
   logic                  eor_ff;
   logic signed [W-1:0]   pen_x_ff, pen_x_in, pen_y_ff, pen_y_in;

   // Advance everything together whenever the output register can take a value.
   assign advance = !rsp_valid_ff || rsp_ready;

   qbsp_seq #(.W(W)) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_kind        (req_kind),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .req_final_point (req_final_point),
      .advance         (advance),
      .tok_ctl         (tok_ctl),
      .tok_j           (tok_j),
      .tok_o_x         (tok_o_x),
      .tok_o_y         (tok_o_y),
      .tok_m_x         (tok_m_x),
      .tok_m_y         (tok_m_y),
      .tok_n_x         (tok_n_x),
      .tok_n_y         (tok_n_y)
   );

   qbsp_blend #(.W(W)) u_blend_x (
      .clock   (clock),
      .advance (advance),
      .j       (tok_j),
      .o       (tok_o_x),
      .m       (tok_m_x),
      .n       (tok_n_x),
      .quot    (quot_x),
      .pt      (pt_x)
   );

   qbsp_blend #(.W(W)) u_blend_y (
      .clock   (clock),
      .advance (advance),
      .j       (tok_j),
      .o       (tok_o_y),
      .m       (tok_m_y),
      .n       (tok_n_y),
      .quot    (quot_y),
      .pt      (pt_y)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
         s2_ctl_ff <= '0;
         s3_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= tok_ctl;
         s2_ctl_ff <= s1_ctl_ff;
         s3_ctl_ff <= s2_ctl_ff;
      end
   end

   // The pen lives at the output: a segment starts where the last one ended,
   // and a start point item only reloads it.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      if (advance) begin
         rsp_valid_in = s3_ctl_ff.valid && !s3_ctl_ff.load;
         if (s3_ctl_ff.valid) begin
            pen_x_in = s3_ctl_ff.load ? pt_x : quot_x;
            pen_y_in = s3_ctl_ff.load ? pt_y : quot_y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pen_x_ff     <= pen_x_in;
         pen_y_ff     <= pen_y_in;
      end
   end

   // Hold the segment while the consumer stalls.
   always_ff @(posedge clock) begin
      if (advance) begin
         from_x_ff <= pen_x_ff;
         from_y_ff <= pen_y_ff;
         to_x_ff   <= quot_x;
         to_y_ff   <= quot_y;
         eor_ff    <= s3_ctl_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_from_x     = from_x_ff;
   assign rsp_from_y     = from_y_ff;
   assign rsp_to_x       = to_x_ff;
   assign rsp_to_y       = to_y_ff;
   assign rsp_end_of_run = eor_ff;

endmodule

// ===== test/tb.sv =====
module tb;
   import qbsp_pkg::SCALE;
   import qbsp_pkg::STEPS;
   import qbsp_pkg::KIND_START;
   import qbsp_pkg::KIND_CONTROL;

   localparam int COORD_WIDTH  = 16;
   localparam int RANDOM_ITEMS = 442;
   // Run the tail of the random part with both sides always ready.
   localparam int STEADY_ITEMS = 90;
   localparam int HOLD_CYCLES  = 300;
   // Margin for the pipeline to settle after the last predicted segment.
   localparam int SETTLE_CYCLES = 10;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   // One line segment as the block emits it.
   typedef struct packed {
      coord_type from_x;
      coord_type from_y;
      coord_type to_x;
      coord_type to_y;
      logic      end_of_run;
   } segment_type;

   logic      clock           = 1'b0;
   logic      reset           = 1'b1;
   logic      req_valid       = 1'b0;
   logic      req_kind        = KIND_START;
   coord_type req_x_coord     = '0;
   coord_type req_y_coord     = '0;
   logic      req_final_point = 1'b0;
   logic      rsp_ready       = 1'b0;
   logic      req_ready;
   logic      rsp_valid;
   coord_type rsp_from_x;
   coord_type rsp_from_y;
   coord_type rsp_to_x;
   coord_type rsp_to_y;
   logic      rsp_end_of_run;

   // Shadow copy of the curve state: the two stored control points and the pen.
   coord_type older_x = '0, older_y = '0;
   coord_type newer_x = '0, newer_y = '0;
   coord_type pen_x   = '0, pen_y   = '0;

   // Segments predicted but not yet seen on the rsp channel, oldest first.
   segment_type pending_segments[$];

   // Random idling on both sides; cleared for the last stretch of the run.
   bit idle_on       = 1'b1;
   // Long hold-off request for the segment sink, in cycles.
   int hold_request  = 0;
   int items_sent    = 0;
   int segments_seen = 0;
   int fail_count    = 0;

   quadratic_bspline_point_generator_top #(
      .COORD_WIDTH(COORD_WIDTH)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_x_coord    (req_x_coord),
      .req_y_coord    (req_y_coord),
      .req_final_point(req_final_point),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_from_x     (rsp_from_x),
      .rsp_from_y     (rsp_from_y),
      .rsp_to_x       (rsp_to_x),
      .rsp_to_y       (rsp_to_y),
      .rsp_end_of_run (rsp_end_of_run)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Curve point j of the span (older, newer, incoming): weights at scale 1000,
   // rounding bias of half the scale, division truncating toward zero.
   function automatic coord_type curve_point(input longint incoming, input longint newer,
                                             input longint older, input int j);
      longint w_in, w_mid, w_old;
      w_in  = 5 * j * j;
      w_mid = 3 * SCALE / 4 - 10 * (j - 5) * (j - 5);
      w_old = 5 * (j - STEPS) * (j - STEPS);
      return coord_type'((w_in * incoming + w_mid * newer + w_old * older + SCALE / 2) / SCALE);
   endfunction

   // Queue the ten segments of one span and advance the pen along it.
   task automatic queue_span(input coord_type ox, input coord_type oy, input coord_type mx,
                             input coord_type my, input coord_type nx, input coord_type ny);
      segment_type seg;
      for (int j = 0; j < STEPS; j++) begin
         seg.from_x     = pen_x;
         seg.from_y     = pen_y;
         seg.to_x       = curve_point(nx, mx, ox, j);
         seg.to_y       = curve_point(ny, my, oy, j);
         seg.end_of_run = 1'b0;
         pending_segments.push_back(seg);
         pen_x = seg.to_x;
         pen_y = seg.to_y;
      end
   endtask

   // Advance the shadow state by one accepted point item.
   task automatic predict_point(input logic kind, input coord_type x, input coord_type y,
                                input logic final_point);
      if (kind == KIND_START) begin
         // A start point fills both stored points and moves the pen; no segment.
         older_x = x; newer_x = x; pen_x = x;
         older_y = y; newer_y = y; pen_y = y;
      end else begin
         queue_span(older_x, older_y, newer_x, newer_y, x, y);
         older_x = newer_x;
         older_y = newer_y;
         newer_x = x;
         newer_y = y;
         // The last point is doubled at the end of the curve.
         if (final_point)
            queue_span(older_x, older_y, newer_x, newer_y, newer_x, newer_y);
         pending_segments[pending_segments.size() - 1].end_of_run = 1'b1;
      end
   endtask

   // Offer one item on req, hold it until accepted, then predict it.
   // Call at a rising edge; returns at the edge that accepts the item.
   task automatic send_point(input logic kind, input coord_type x, input coord_type y,
                             input logic final_point);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_x_coord     <= x;
      req_y_coord     <= y;
      req_final_point <= final_point;
      do @(posedge clock); while (!req_ready);
      predict_point(kind, x, y, final_point);
      items_sent++;
   endtask

   // Mix of extremes, small values near zero and full-range values.
   function automatic coord_type rand_coord();
      case ($urandom_range(0, 9))
         0:       return coord_type'(32767);
         1:       return coord_type'(-32768);
         2:       return '0;
         3, 4, 5: return coord_type'($urandom_range(0, 400) - 200);
         default: return coord_type'($urandom);
      endcase
   endfunction

   task automatic check_field(input string name, input logic signed [31:0] expected,
                              input logic signed [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         fail_count++;
      end
   endtask

   // Segment sink: random stall bursts, plus a long hold-off on request.
   initial begin : segment_sink
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request > 0) begin
            stall_left   = hold_request - 1;
            hold_request = 0;
            rsp_ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Compare each accepted segment with the oldest prediction.
   always @(posedge clock) begin
      segment_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         segments_seen++;
         if (pending_segments.size() == 0) begin
            $error("segment with nothing predicted: from (%0d,%0d) to (%0d,%0d)",
                   rsp_from_x, rsp_from_y, rsp_to_x, rsp_to_y);
            fail_count++;
         end else begin
            want = pending_segments.pop_front();
            check_field("from_x", want.from_x, rsp_from_x);
            check_field("from_y", want.from_y, rsp_from_y);
            check_field("to_x", want.to_x, rsp_to_x);
            check_field("to_y", want.to_y, rsp_to_y);
            check_field("end_of_run", {31'b0, want.end_of_run}, {31'b0, rsp_end_of_run});
         end
      end
   end

   // Corners: control before any start point, start point with final set,
   // extreme coordinates, a control point after a final one, a degenerate
   // curve and rounding around minus one.
   task automatic test_directed();
      send_point(KIND_CONTROL, 16'sd100, -16'sd200, 1'b0);
      send_point(KIND_START, 16'sd32767, -16'sd32768, 1'b1);
      send_point(KIND_CONTROL, 16'sd32767, 16'sd32767, 1'b0);
      send_point(KIND_CONTROL, -16'sd32768, -16'sd32768, 1'b1);
      send_point(KIND_CONTROL, -16'sd32768, 16'sd32767, 1'b0);
      send_point(KIND_CONTROL, 16'sd32767, -16'sd32768, 1'b1);
      send_point(KIND_START, -16'sd32768, -16'sd32768, 1'b0);
      send_point(KIND_CONTROL, -16'sd32768, -16'sd32768, 1'b1);
      send_point(KIND_START, 16'sd0, 16'sd0, 1'b0);
      send_point(KIND_CONTROL, -16'sd1, -16'sd1, 1'b0);
      send_point(KIND_CONTROL, 16'sd1, -16'sd1, 1'b0);
      send_point(KIND_CONTROL, -16'sd3, 16'sd2, 1'b1);
      send_point(KIND_START, 16'sd32767, 16'sd32767, 1'b0);
      send_point(KIND_CONTROL, -16'sd32768, 16'sd32767, 1'b0);
      send_point(KIND_CONTROL, 16'sd32767, -16'sd32768, 1'b1);
   endtask

   // Hold off the sink for a long stretch while points keep coming, so the
   // pipeline fills and req_ready drops.
   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      send_point(KIND_START, rand_coord(), rand_coord(), 1'b0);
      for (int k = 0; k < 12; k++)
         send_point(KIND_CONTROL, rand_coord(), rand_coord(), k == 11);
   endtask

   // Mostly well-formed curves with random content; the rest is loose points
   // of either kind with a random final bit.
   task automatic test_random_curves();
      int sent, n;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - STEADY_ITEMS)
            idle_on = 1'b0;
         if ($urandom_range(0, 9) < 8) begin
            n = $urandom_range(1, 6);
            send_point(KIND_START, rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
            for (int k = 0; k < n; k++)
               send_point(KIND_CONTROL, rand_coord(), rand_coord(), k == n - 1);
            sent += n + 1;
         end else begin
            send_point(1'($urandom_range(0, 1)), rand_coord(), rand_coord(),
                       1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   initial begin : main
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random_curves();
      req_valid <= 1'b0;
      // Drain what is still in flight, then let the pipeline settle.
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d point items and %0d segments, directed corners and random curves,",
               items_sent, segments_seen);
      $display("with idle bursts on both sides and a %0d-cycle hold-off on the segment side",
               HOLD_CYCLES);
      if (fail_count == 0)
         $display("quadratic_bspline_point_generator_top regression: pass");
      else
         $display("quadratic_bspline_point_generator_top regression: fail");
      $finish;
   end

   // Generous cap well beyond the slowest correct run.
   initial begin : watchdog
      #1000000;
      $display("quadratic_bspline_point_generator_top regression: fail");
      $finish;
   end

endmodule
